// ===== rtl/pstk_pkg.sv =====
// ----------------------------------------------------------------------------
// pstk_pkg
// shared widths, payload words, config register codes and control structs
// for the peak search / top-k decision block
// ----------------------------------------------------------------------------
`default_nettype none

package pstk_pkg;

  localparam int PowerBits      = 40;
  localparam int BinBits        = 6;
  localparam int PhaseBits      = 11;
  localparam int MetricFracBits = 16;
  localparam int ThreshBits     = MetricFracBits + 1;
  localparam int CfgIdxBits     = 2;
  localparam int CfgDataBits    = 32;

  // config register indexes
  localparam logic [CfgIdxBits-1:0] CfgIdxMode   = CfgIdxBits'(0);
  localparam logic [CfgIdxBits-1:0] CfgIdxThresh = CfgIdxBits'(1);

  // decision modes
  localparam logic ModeFixed    = 1'b0;
  localparam logic ModeVariance = 1'b1;

  // input word
  typedef struct packed {
    logic [PowerBits-1:0] peak_power;
    logic [BinBits-1:0]   doppler_bin;
    logic [PhaseBits-1:0] code_phase;
    logic                 sweep_end;
  } pstk_in_t;

  // result word
  typedef struct packed {
    logic [BinBits-1:0]   best_bin;
    logic [PhaseBits-1:0] best_phase;
    logic [PowerBits-1:0] best_power;
    logic                 detected;
  } pstk_out_t;

  // controller to datapath
  typedef struct packed {
    logic load;
    logic update;
    logic div_start;
    logic diff;
    logic square;
    logic finish;
  } pstk_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic last;
    logic mode;
    logic div_done;
  } pstk_status_t;

endpackage : pstk_pkg

`default_nettype wire

// ===== rtl/pstk_divider.sv =====
// ----------------------------------------------------------------------------
// pstk_divider
// restoring divider, floor(num * 2^F / den) for num <= den, one bit a cycle
// ----------------------------------------------------------------------------
`default_nettype none

module pstk_divider
  import pstk_pkg::*;
(
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire logic                      start_i,
  input  wire logic [PowerBits-1:0]      num_i,
  input  wire logic [PowerBits-1:0]      den_i,
  output logic                           done_o,
  output logic [MetricFracBits:0]        quot_o
);

  localparam int CntBits = $clog2(MetricFracBits);

  logic                   run_q;
  logic                   done_q;
  logic [CntBits-1:0]     cnt_q;
  logic [PowerBits-1:0]   rem_q;
  logic [PowerBits-1:0]   den_q;
  logic [MetricFracBits:0] quot_q;

  logic [PowerBits:0]     rem_sh;
  logic [PowerBits:0]     rem_sub;
  logic                   ge;
  logic                   ge0;
  logic [PowerBits-1:0]   rem_d;

  always_comb begin
    rem_sh  = {rem_q, 1'b0};
    rem_sub = rem_sh - {1'b0, den_q};
    ge      = rem_sh >= {1'b0, den_q};
    rem_d   = ge ? rem_sub[PowerBits-1:0] : rem_sh[PowerBits-1:0];
    ge0     = num_i >= den_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        run_q <= 1'b1;
        cnt_q <= '0;
      end else if (run_q) begin
        cnt_q <= cnt_q + CntBits'(1);
        if (cnt_q == CntBits'(MetricFracBits - 1)) begin
          run_q  <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  // datapath registers, no reset needed
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      den_q  <= den_i;
      quot_q <= {{MetricFracBits{1'b0}}, ge0};
      rem_q  <= ge0 ? (num_i - den_i) : num_i;
    end else if (run_q) begin
      rem_q  <= rem_d;
      quot_q <= {quot_q[MetricFracBits-1:0], ge};
    end
  end

  assign done_o = done_q;
  assign quot_o = quot_q;

endmodule : pstk_divider

`default_nettype wire

// ===== rtl/pstk_datapath.sv =====
// ----------------------------------------------------------------------------
// pstk_datapath
// running maximum, sorted top-k list, ratio and variance metric, result word
// ----------------------------------------------------------------------------
`default_nettype none

module pstk_datapath
  import pstk_pkg::*;
#(
  parameter int TopCount = 8
) (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire pstk_in_t               item_i,
  input  wire logic                   cfg_we_i,
  input  wire logic [CfgIdxBits-1:0]  cfg_index_i,
  input  wire logic [CfgDataBits-1:0] cfg_data_i,
  input  wire pstk_cmd_t              cmd_i,
  output pstk_status_t                status_o,
  output logic                        result_valid_o,
  output pstk_out_t                   result_o
);

  localparam logic [MetricFracBits+1:0] OneWide = (MetricFracBits+2)'(1) << MetricFracBits;

  // config
  logic                  mode_q;
  logic [ThreshBits-1:0] thr_q;

  // sweep state
  pstk_in_t              in_q;
  logic [PowerBits-1:0]  max_pow_q;
  logic [BinBits-1:0]    max_bin_q;
  logic [PhaseBits-1:0]  max_phase_q;
  logic [PowerBits-1:0]  list_q [TopCount];
  logic [PowerBits-1:0]  list_d [TopCount];
  logic [TopCount-1:0]   gt;

  // metric pipeline
  logic [MetricFracBits:0]     quot;
  logic                        div_done;
  logic [MetricFracBits-1:0]   d1_q, d2_q;
  logic [2*MetricFracBits-1:0] sq1_q, sq2_q;

  logic [MetricFracBits+1:0]   rho2;
  logic [MetricFracBits+1:0]   mean;
  logic [MetricFracBits+1:0]   d1_w, d2_w;
  logic [2*MetricFracBits:0]   sum;
  logic [ThreshBits-1:0]       var_ext;
  logic                        nonzero;
  logic                        detect;

  pstk_divider u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (cmd_i.div_start),
    .num_i   (list_q[TopCount-1]),
    .den_i   (list_q[0]),
    .done_o  (div_done),
    .quot_o  (quot)
  );

  // sorted insert: new power lands below every entry that is >= it
  always_comb begin
    for (int k = 0; k < TopCount; k++) begin
      gt[k] = in_q.peak_power > list_q[k];
    end
    list_d[0] = gt[0] ? in_q.peak_power : list_q[0];
    for (int k = 1; k < TopCount; k++) begin
      if (!gt[k]) begin
        list_d[k] = list_q[k];
      end else if (gt[k-1]) begin
        list_d[k] = list_q[k-1];
      end else begin
        list_d[k] = in_q.peak_power;
      end
    end
  end

  // ratio, mean, deviations, variance and detect decision
  always_comb begin
    rho2 = (list_q[0] == '0) ? '0 : {1'b0, quot};
    mean = (OneWide + rho2) >> 1;
    d1_w = OneWide - mean;
    d2_w = mean - rho2;
    sum  = {1'b0, sq1_q} + {1'b0, sq2_q};
    var_ext = {1'b0, sum[2*MetricFracBits:MetricFracBits+1]};
    nonzero = max_pow_q != '0;
    detect  = (mode_q == ModeVariance) ? ((var_ext > thr_q) && nonzero) : nonzero;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q         <= ModeFixed;
      thr_q          <= '0;
      max_pow_q      <= '0;
      max_bin_q      <= '0;
      max_phase_q    <= '0;
      result_valid_o <= 1'b0;
      for (int k = 0; k < TopCount; k++) begin
        list_q[k] <= '0;
      end
    end else begin
      result_valid_o <= cmd_i.finish;
      if (cfg_we_i) begin
        unique case (cfg_index_i)
          CfgIdxMode:   mode_q <= cfg_data_i[0];
          CfgIdxThresh: thr_q  <= cfg_data_i[ThreshBits-1:0];
          default: ;
        endcase
      end
      if (cmd_i.update) begin
        if (in_q.peak_power > max_pow_q) begin
          max_pow_q   <= in_q.peak_power;
          max_bin_q   <= in_q.doppler_bin;
          max_phase_q <= in_q.code_phase;
        end
        if (mode_q == ModeVariance) begin
          for (int k = 0; k < TopCount; k++) begin
            list_q[k] <= list_d[k];
          end
        end
      end else if (cmd_i.finish) begin
        max_pow_q   <= '0;
        max_bin_q   <= '0;
        max_phase_q <= '0;
        for (int k = 0; k < TopCount; k++) begin
          list_q[k] <= '0;
        end
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      in_q <= item_i;
    end
    if (cmd_i.diff) begin
      d1_q <= d1_w[MetricFracBits-1:0];
      d2_q <= d2_w[MetricFracBits-1:0];
    end
    if (cmd_i.square) begin
      sq1_q <= d1_q * d1_q;
      sq2_q <= d2_q * d2_q;
    end
    if (cmd_i.finish) begin
      result_o.best_bin   <= max_bin_q;
      result_o.best_phase <= max_phase_q;
      result_o.best_power <= max_pow_q;
      result_o.detected   <= detect;
    end
  end

  assign status_o.last     = in_q.sweep_end;
  assign status_o.mode     = mode_q;
  assign status_o.div_done = div_done;

endmodule : pstk_datapath

`default_nettype wire

// ===== rtl/pstk_ctrl.sv =====
// ----------------------------------------------------------------------------
// pstk_ctrl
// sequencer: take a word, update the sweep state, run the decision at sweep end
// ----------------------------------------------------------------------------
`default_nettype none

module pstk_ctrl
  import pstk_pkg::*;
(
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         start_i,
  input  wire pstk_status_t status_i,
  output pstk_cmd_t         cmd_o,
  output logic              busy_o
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_UPDATE,
    ST_DIV_START,
    ST_DIV_WAIT,
    ST_DIFF,
    ST_SQUARE,
    ST_DECIDE
  } state_e;

  state_e state_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      unique case (state_q)
        ST_IDLE: begin
          if (start_i) state_q <= ST_UPDATE;
        end
        ST_UPDATE: begin
          priority if (!status_i.last)           state_q <= ST_IDLE;
          else if (status_i.mode == ModeFixed)   state_q <= ST_DECIDE;
          else                                   state_q <= ST_DIV_START;
        end
        ST_DIV_START: state_q <= ST_DIV_WAIT;
        ST_DIV_WAIT: begin
          if (status_i.div_done) state_q <= ST_DIFF;
        end
        ST_DIFF:   state_q <= ST_SQUARE;
        ST_SQUARE: state_q <= ST_DECIDE;
        ST_DECIDE: state_q <= ST_IDLE;
        default:   state_q <= ST_IDLE;
      endcase
    end
  end

  always_comb begin
    cmd_o           = '0;
    cmd_o.load      = (state_q == ST_IDLE) && start_i;
    cmd_o.update    = state_q == ST_UPDATE;
    cmd_o.div_start = state_q == ST_DIV_START;
    cmd_o.diff      = state_q == ST_DIFF;
    cmd_o.square    = state_q == ST_SQUARE;
    cmd_o.finish    = state_q == ST_DECIDE;
    busy_o          = state_q != ST_IDLE;
  end

endmodule : pstk_ctrl

`default_nettype wire

// ===== rtl/peak_search_top_k_decision.sv =====
// ----------------------------------------------------------------------------
// peak_search_top_k_decision
// running argmax over a sweep of correlation words with a top-k peak ratio
// variance test, one result word per sweep
// ----------------------------------------------------------------------------
//
// channel   direction  handshake                    payload
// --------  ---------  ---------------------------  -----------------------------
// item      in         start_i & !busy_o            item_i (pstk_in_t)
// result    out        result_valid_o, 1 cycle      result_o (pstk_out_t)
// config    in         cfg_valid_i & cfg_ready_o    cfg_index_i, cfg_data_i
//
// - a word that does not end the sweep passes the accept cycle and the update
//   state, in which the maximum and, in variance mode, the sorted top list change
// - a sweep end word in fixed mode goes from update to decide, the result strobe follows
// - a sweep end word in variance mode waits for the one-bit-a-cycle ratio
//   divider, then steps through deviations, squares and the threshold compare
// - reset (rst_ni low, async) clears config, sweep state and the sequencer;
//   sweep state is also cleared when the result word is produced
// - results are shown for one cycle and cannot be stalled; the next word may
//   be accepted in the cycle the result strobe is high
// - config writes are always ready
// ----------------------------------------------------------------------------
`default_nettype none

module peak_search_top_k_decision
  import pstk_pkg::*;
#(
  parameter int TopCount = 8
) (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  // item channel
  input  wire logic                   start_i,
  output logic                        busy_o,
  input  wire pstk_in_t               item_i,
  // result channel
  output logic                        result_valid_o,
  output pstk_out_t                   result_o,
  // config channel
  input  wire logic                   cfg_valid_i,
  output logic                        cfg_ready_o,
  input  wire logic [CfgIdxBits-1:0]  cfg_index_i,
  input  wire logic [CfgDataBits-1:0] cfg_data_i
);

  pstk_cmd_t    cmd;
  pstk_status_t status;
  logic         cfg_we;

  // config never back-pressures
  assign cfg_ready_o = 1'b1;
  assign cfg_we      = cfg_valid_i && cfg_ready_o;

  // sequencer
  pstk_ctrl u_ctrl (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (start_i),
    .status_i (status),
    .cmd_o    (cmd),
    .busy_o   (busy_o)
  );

  // max tracker, top list, ratio divider, variance metric
  pstk_datapath #(
    .TopCount (TopCount)
  ) u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .item_i         (item_i),
    .cfg_we_i       (cfg_we),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i),
    .cmd_i          (cmd),
    .status_o       (status),
    .result_valid_o (result_valid_o),
    .result_o       (result_o)
  );

  // an accepted word always occupies the sequencer for the next cycle
  a_accept_busy : assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i && !busy_o |=> busy_o)
    else $error("accepted word did not make the block busy");

  // one sweep gives one result word, never back to back strobes
  a_single_strobe : assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |=> !result_valid_o)
    else $error("result strobe held longer than one cycle");

  // a detection needs a nonzero peak
  a_detect_power : assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o && result_o.detected |-> result_o.best_power != '0)
    else $error("detection reported with zero best power");

  // the result strobe only follows the decide step, when the block is idle
  a_strobe_idle : assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> !busy_o)
    else $error("result strobe while sequencer busy");

endmodule : peak_search_top_k_decision

`default_nettype wire

// ===== tb/peak_search_top_k_decision_test.sv =====
// ----------------------------------------------------------------------------
// peak_search_top_k_decision_test
// self-checking bench for the peak search block: a directed table of sweeps
// and register writes, then random sweeps under random start gaps; a typed
// row's result is checked against the row, any other against a running model
// of the sweep maximum, sorted top-k list and peak ratio variance decision
// ----------------------------------------------------------------------------

module peak_search_top_k_decision_test;
  import pstk_pkg::*;

  localparam int TopCount      = 8;
  localparam int RandomItems   = 1100;
  localparam int MaxGap        = 11;
  // a variance sweep end keeps the block busy while the divider runs
  localparam int SettleCycles  = MetricFracBits + 14;
  localparam int DrainLimit    = 500;
  localparam int WatchdogLimit = 2000;

  localparam logic [PowerBits-1:0] PowerMax  = {PowerBits{1'b1}};
  localparam logic [63:0]          MetricOne = 64'd1 << MetricFracBits;

  typedef enum logic {RowItem, RowCfg} row_kind_e;

  // one line of the directed table: a word to send or a register to write
  typedef struct {
    row_kind_e               kind;
    logic [CfgIdxBits-1:0]   reg_idx;
    logic [CfgDataBits-1:0]  reg_data;
    pstk_in_t                word;
    bit                      typed;
    pstk_out_t               want;
  } stim_row_t;

  logic                   clk_i;
  logic                   rst_ni      = 1'b0;
  logic                   start_i     = 1'b0;
  logic                   busy_o;
  pstk_in_t               item_i      = '0;
  logic                   result_valid_o;
  pstk_out_t              result_o;
  logic                   cfg_valid_i = 1'b0;
  logic                   cfg_ready_o;
  logic [CfgIdxBits-1:0]  cfg_index_i = '0;
  logic [CfgDataBits-1:0] cfg_data_i  = '0;

  peak_search_top_k_decision #(
    .TopCount(TopCount)
  ) dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .start_i       (start_i),
    .busy_o        (busy_o),
    .item_i        (item_i),
    .result_valid_o(result_valid_o),
    .result_o      (result_o),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i)
  );

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  // ---------------------------------------------------------------------------
  // sweep model: register copies and per-sweep state
  // ---------------------------------------------------------------------------
  logic                  cur_mode;
  logic [ThreshBits-1:0] cur_thresh;
  logic [PowerBits-1:0]  sw_max_power;
  logic [BinBits-1:0]    sw_max_bin;
  logic [PhaseBits-1:0]  sw_max_phase;
  logic [PowerBits-1:0]  top_powers [TopCount];   // largest first

  pstk_out_t pending_results [$];
  int        error_count = 0;

  task automatic clear_sweep();
    sw_max_power = '0;
    sw_max_bin   = '0;
    sw_max_phase = '0;
    foreach (top_powers[i]) top_powers[i] = '0;
  endtask

  // detect when the Q16 variance of {1, smallest/largest top power} exceeds the threshold with a nonzero peak
  function automatic logic peak_ratio_detect();
    logic [63:0] rho, mid, dev_a, dev_b, spread;
    rho = '0;
    if (top_powers[0] != '0)
      rho = (64'(top_powers[TopCount-1]) << MetricFracBits) / 64'(top_powers[0]);
    mid    = (MetricOne + rho) >> 1;
    dev_a  = MetricOne - mid;
    dev_b  = mid - rho;
    // full-precision sum, truncated once
    spread = (dev_a * dev_a + dev_b * dev_b) >> (MetricFracBits + 1);
    return (spread > 64'(cur_thresh)) && (sw_max_power != '0);
  endfunction

  // takes one accepted word into the model, returns the result word it causes
  task automatic track_sweep(input pstk_in_t w, output bit emits, output pstk_out_t res);
    int k;
    // strict compare: the first occurrence of the maximum wins
    if (w.peak_power > sw_max_power) begin
      sw_max_power = w.peak_power;
      sw_max_bin   = w.doppler_bin;
      sw_max_phase = w.code_phase;
    end
    // sorted insert, a power equal to the smallest kept one is dropped
    if (cur_mode == ModeVariance && w.peak_power > top_powers[TopCount-1]) begin
      k = TopCount - 1;
      while (k > 0 && top_powers[k-1] < w.peak_power) begin
        top_powers[k] = top_powers[k-1];
        k--;
      end
      top_powers[k] = w.peak_power;
    end
    emits = w.sweep_end;
    res   = '0;
    if (w.sweep_end) begin
      res.best_bin   = sw_max_bin;
      res.best_phase = sw_max_phase;
      res.best_power = sw_max_power;
      res.detected   = (cur_mode == ModeFixed) ? (sw_max_power != '0) : peak_ratio_detect();
      clear_sweep();
    end
  endtask

  // ---------------------------------------------------------------------------
  // drivers
  // ---------------------------------------------------------------------------

  // start stays high from one word to the next when the gap is zero
  task automatic send_word(input pstk_in_t w, input int gap, input bit typed,
                           input pstk_out_t want);
    bit        emits;
    pstk_out_t res;
    if (gap > 0) begin
      start_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    start_i <= 1'b1;
    item_i  <= w;
    do @(posedge clk_i); while (busy_o);
    track_sweep(w, emits, res);
    // typed rows carry their own expectation, the model still tracks state
    if (emits) pending_results.push_back(typed ? want : res);
  endtask

  // an idle wait after the write keeps valid from dropping and rising at once
  task automatic write_reg(input logic [CfgIdxBits-1:0] idx,
                           input logic [CfgDataBits-1:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    if (idx == CfgIdxMode)
      cur_mode = data[0];
    else if (idx == CfgIdxThresh)
      cur_thresh = data[ThreshBits-1:0];
    @(posedge clk_i);
  endtask

  // hold off until every pending result has come and the block has gone quiet
  task automatic settle_block();
    start_i <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  // mostly inside the reachable variance range 0..16384, plus the extremes
  function automatic logic [CfgDataBits-1:0] draw_threshold();
    case ($urandom_range(0, 7))
      0:       return CfgDataBits'(0);
      1:       return CfgDataBits'(16383);
      2:       return CfgDataBits'(16384);
      3:       return CfgDataBits'(65536);
      4:       return CfgDataBits'($urandom_range(0, 65536));
      default: return CfgDataBits'($urandom_range(0, 16384));
    endcase
  endfunction

  // powers clustered under a per-sweep base so the top-k ratio spreads out
  function automatic logic [PowerBits-1:0] draw_power(input logic [PowerBits-1:0] base);
    logic [63:0] r;
    r = {$urandom, $urandom};
    case ($urandom_range(0, 11))
      0:       return '0;
      1:       return PowerMax;
      2:       return r[PowerBits-1:0];
      3:       return base;
      default: return base - ((base >> $urandom_range(0, 8)) & r[PowerBits-1:0]);
    endcase
  endfunction

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    $display("mismatch at %0t: %s got %0h expected %0h", $realtime, what, got, want);
    error_count++;
  endtask

  // ---------------------------------------------------------------------------
  // result checker: strobed words are compared with the oldest expectation
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) begin : result_check
    pstk_out_t want;
    if (rst_ni && result_valid_o) begin
      if (pending_results.size() == 0) begin
        report_mismatch("result word with nothing pending", 64'(result_o), 64'd0);
      end else begin
        want = pending_results.pop_front();
        if (result_o.best_bin !== want.best_bin)
          report_mismatch("best_bin", 64'(result_o.best_bin), 64'(want.best_bin));
        if (result_o.best_phase !== want.best_phase)
          report_mismatch("best_phase", 64'(result_o.best_phase), 64'(want.best_phase));
        if (result_o.best_power !== want.best_power)
          report_mismatch("best_power", 64'(result_o.best_power), 64'(want.best_power));
        if (result_o.detected !== want.detected)
          report_mismatch("detected", 64'(result_o.detected), 64'(want.detected));
      end
    end
  end

  // watchdog: any accepted word or write, or a result strobe, counts as progress
  always @(posedge clk_i) begin : watchdog
    int stall_cycles;
    if ((start_i && !busy_o) || result_valid_o || (cfg_valid_i && cfg_ready_o))
      stall_cycles = 0;
    else
      stall_cycles = stall_cycles + 1;
    if (stall_cycles >= WatchdogLimit) begin
      $display("peak_search_top_k_decision_test: FAIL");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // stimulus
  // ---------------------------------------------------------------------------
  stim_row_t dir_rows [$];

  initial begin : stimulus
    pstk_in_t             w;
    logic [63:0]          r;
    logic [PowerBits-1:0] base;
    int                   random_sent;
    int                   sweep_len;
    int                   drain_wait;
    bit                   no_idle;

    cur_mode   = ModeFixed;
    cur_thresh = '0;
    clear_sweep();

    // after reset, fixed mode: an all-zero sweep reports zeros, no detection
    dir_rows.push_back('{RowItem, CfgIdxMode, '0, {40'd0, 6'd5, 11'd7, 1'b1},
                         1'b1, {6'd0, 11'd0, 40'd0, 1'b0}});
    // field extremes in a single-word sweep
    dir_rows.push_back('{RowItem, CfgIdxMode, '0, {PowerMax, 6'd63, 11'd2047, 1'b1},
                         1'b1, {6'd63, 11'd2047, PowerMax, 1'b1}});
    // equal powers, the first occurrence keeps bin and phase
    dir_rows.push_back('{RowItem, CfgIdxMode, '0, {40'd100, 6'd1, 11'd1, 1'b0}, 1'b0, '0});
    dir_rows.push_back('{RowItem, CfgIdxMode, '0, {40'd100, 6'd2, 11'd2, 1'b0}, 1'b0, '0});
    dir_rows.push_back('{RowItem, CfgIdxMode, '0, {40'd50, 6'd3, 11'd3, 1'b1},
                         1'b1, {6'd1, 11'd1, 40'd100, 1'b1}});
    // variance mode, threshold still zero: lone peak gives the largest variance
    dir_rows.push_back('{RowCfg, CfgIdxMode, CfgDataBits'(ModeVariance), '0, 1'b0, '0});
    dir_rows.push_back('{RowItem, CfgIdxMode, '0, {40'd1000, 6'd0, 11'd2047, 1'b1},
                         1'b1, {6'd0, 11'd2047, 40'd1000, 1'b1}});
    // full list of equal powers: ratio one, zero variance, no detection
    for (int i = 0; i < TopCount; i++)
      dir_rows.push_back('{RowItem, CfgIdxMode, '0,
                           {40'd500, 6'(10 + i), 11'(100 + i), i == TopCount - 1},
                           i == TopCount - 1, {6'd10, 11'd100, 40'd500, 1'b0}});
    // threshold at and above the largest variance: nothing detected
    dir_rows.push_back('{RowCfg, CfgIdxThresh, CfgDataBits'(65536), '0, 1'b0, '0});
    dir_rows.push_back('{RowItem, CfgIdxMode, '0, {40'd77, 6'd4, 11'd4, 1'b1},
                         1'b1, {6'd4, 11'd4, 40'd77, 1'b0}});
    dir_rows.push_back('{RowCfg, CfgIdxThresh, CfgDataBits'(16384), '0, 1'b0, '0});
    dir_rows.push_back('{RowItem, CfgIdxMode, '0, {40'd1, 6'd5, 11'd5, 1'b1},
                         1'b1, {6'd5, 11'd5, 40'd1, 1'b0}});
    // one below the largest variance detects
    dir_rows.push_back('{RowCfg, CfgIdxThresh, CfgDataBits'(16383), '0, 1'b0, '0});
    dir_rows.push_back('{RowItem, CfgIdxMode, '0, {40'd1, 6'd6, 11'd6, 1'b1},
                         1'b1, {6'd6, 11'd6, 40'd1, 1'b1}});
    // zero largest power: ratio forced to zero but a zero peak never detects
    dir_rows.push_back('{RowItem, CfgIdxMode, '0, {40'd0, 6'd1, 11'd1, 1'b1},
                         1'b1, {6'd0, 11'd0, 40'd0, 1'b0}});
    // mode flipped inside a sweep: the fixed-mode word stays off the top list
    dir_rows.push_back('{RowItem, CfgIdxMode, '0, {40'd900, 6'd9, 11'd9, 1'b0}, 1'b0, '0});
    dir_rows.push_back('{RowCfg, CfgIdxMode, CfgDataBits'(ModeFixed), '0, 1'b0, '0});
    dir_rows.push_back('{RowItem, CfgIdxMode, '0, {40'd2000, 6'd10, 11'd10, 1'b0}, 1'b0, '0});
    dir_rows.push_back('{RowCfg, CfgIdxMode, CfgDataBits'(ModeVariance), '0, 1'b0, '0});
    dir_rows.push_back('{RowItem, CfgIdxMode, '0, {40'd0, 6'd63, 11'd0, 1'b1}, 1'b0, '0});

    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed table, register writes only once the block is quiet
    foreach (dir_rows[i]) begin
      if (dir_rows[i].kind == RowCfg) begin
        settle_block();
        write_reg(dir_rows[i].reg_idx, dir_rows[i].reg_data);
      end else begin
        send_word(dir_rows[i].word, $urandom_range(0, MaxGap), dir_rows[i].typed,
                  dir_rows[i].want);
      end
    end

    // random phases: new register settings, then a few sweeps each
    random_sent = 0;
    while (random_sent < RandomItems) begin
      settle_block();
      if ($urandom_range(0, 3) != 0)
        write_reg(CfgIdxMode, CfgDataBits'($urandom_range(0, 1)));
      if ($urandom_range(0, 3) != 0)
        write_reg(CfgIdxThresh, draw_threshold());
      // some phases run back to back with no idle cycles at all
      no_idle = ($urandom_range(0, 2) == 0);
      repeat ($urandom_range(3, 10)) begin
        sweep_len = ($urandom_range(0, 7) == 0) ? $urandom_range(15, 40)
                                                : $urandom_range(1, 12);
        r    = {$urandom, $urandom};
        base = r[PowerBits-1:0] >> $urandom_range(0, PowerBits - 1);
        for (int i = 0; i < sweep_len; i++) begin
          // now and then the mode flips between two words of a sweep
          if (i > 0 && $urandom_range(0, 40) == 0) begin
            settle_block();
            write_reg(CfgIdxMode, CfgDataBits'(!cur_mode));
          end
          w.peak_power  = draw_power(base);
          w.doppler_bin = BinBits'($urandom_range(0, 63));
          w.code_phase  = PhaseBits'($urandom_range(0, 2047));
          w.sweep_end   = (i == sweep_len - 1);
          send_word(w, no_idle ? 0 : $urandom_range(0, MaxGap), 1'b0, '0);
          random_sent++;
        end
        // now and then the sender holds off until all results are back
        if ($urandom_range(0, 9) == 0) settle_block();
      end
    end

    // drain, bounded, then a quiet tail to catch stray strobes
    start_i <= 1'b0;
    drain_wait = 0;
    while (pending_results.size() != 0 && drain_wait < DrainLimit) begin
      @(posedge clk_i);
      drain_wait++;
    end
    foreach (pending_results[i])
      report_mismatch("result word never seen", 64'd0, 64'(pending_results[i]));
    repeat (SettleCycles) @(posedge clk_i);

    if (error_count == 0) begin
      $display("peak_search_top_k_decision_test: PASS");
    end else begin
      $display("peak_search_top_k_decision_test: FAIL");
    end
    $finish;
  end

endmodule
